FILE: src/zrbe_pkg.sv
package zrbe_pkg;

   // largest number of bytes that one sample can cause
   localparam int unsigned MaxBurst = 8;
   localparam int unsigned BurstCountWidth = $clog2(MaxBurst + 1);

   // byte codes of the stream
   localparam logic [7:0] CodePosByte  = 8'd101;
   localparam logic [7:0] CodeNegByte  = 8'd102;
   localparam logic [7:0] CodePosWord  = 8'd103;
   localparam logic [7:0] CodeNegWord  = 8'd104;
   localparam logic [7:0] CodeRunByte  = 8'd105;
   localparam logic [7:0] CodeRunWord  = 8'd106;
   localparam logic [7:0] CodeLiteral  = 8'd255;

   // value and run limits
   localparam logic [7:0]  ValueBias   = 8'd180;
   localparam logic [15:0] RunShortMax = 16'd100;
   localparam logic [15:0] RunByteMax  = 16'd255;
   localparam logic [15:0] RunFull     = 16'd65535;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic               block_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       item_done;
   } rsp_payload_type;

   // bytes caused by one sample, byte 0 in the low bits goes out first
   typedef struct packed {
      logic [MaxBurst*8-1:0]        bytes;
      logic [BurstCountWidth-1:0]   count;
   } burst_type;

endpackage

FILE: src/zrbe_encoder.sv
module zrbe_encoder
   import zrbe_pkg::*;
(
   input  req_payload_type item,
   input  logic [15:0]     run_count,
   output burst_type       burst,
   output logic [15:0]     run_count_next
);

   logic        is_zero;
   logic        run_full;
   logic [15:0] run_len;
   logic        do_flush;
   logic [23:0] flush_bytes;
   logic [1:0]  flush_n;
   logic [31:0] run_bytes;
   logic [2:0]  run_n;
   logic [31:0] mag;
   logic [63:0] val_bytes;
   logic [2:0]  val_n;
   logic signed [31:0] v;

   assign v        = item.sample_value;
   assign is_zero  = (v == 32'sd0);
   assign run_full = (run_count == RunFull);

   // zero run that is flushed by this sample
   always_comb begin
      run_len  = run_count;
      do_flush = 1'b1;
      if (is_zero) begin
         run_len  = run_full ? 16'd1 : run_count + 16'd1;
         do_flush = item.block_end;
      end
   end

   // run code
   always_comb begin
      flush_bytes = '0;
      flush_n     = 2'd0;
      if (do_flush && run_len != 16'd0) begin
         if (run_len > RunByteMax) begin
            flush_bytes = {run_len[7:0], run_len[15:8], CodeRunWord};
            flush_n     = 2'd3;
         end else if (run_len > RunShortMax) begin
            flush_bytes = {8'h00, run_len[7:0], CodeRunByte};
            flush_n     = 2'd2;
         end else begin
            flush_bytes = {16'h0000, run_len[7:0]};
            flush_n     = 2'd1;
         end
      end
   end

   // full counter writes a maximal run ahead of the flush
   always_comb begin
      if (is_zero && run_full) begin
         run_bytes = {flush_bytes[7:0], 8'hFF, 8'hFF, CodeRunWord};
         run_n     = 3'd3 + {1'b0, flush_n};
      end else begin
         run_bytes = {8'h00, flush_bytes};
         run_n     = {1'b0, flush_n};
      end
   end

   // value code
   assign mag = 32'd0 - v;

   always_comb begin
      val_bytes = '0;
      val_n     = 3'd0;
      if (!is_zero) begin
         if (v > -32'sd74 && v < 32'sd75) begin
            val_bytes[7:0] = v[7:0] + ValueBias;
            val_n          = 3'd1;
         end else if (v > 32'sd0 && v < 32'sd256) begin
            val_bytes[15:0] = {v[7:0], CodePosByte};
            val_n           = 3'd2;
         end else if (v > 32'sd0 && v < 32'sd65536) begin
            val_bytes[23:0] = {v[7:0], v[15:8], CodePosWord};
            val_n           = 3'd3;
         end else if (v < 32'sd0 && v > -32'sd256) begin
            val_bytes[15:0] = {mag[7:0], CodeNegByte};
            val_n           = 3'd2;
         end else if (v < 32'sd0 && v > -32'sd65536) begin
            val_bytes[23:0] = {mag[7:0], mag[15:8], CodeNegWord};
            val_n           = 3'd3;
         end else begin
            val_bytes[39:0] = {v[7:0], v[15:8], v[23:16], v[31:24], CodeLiteral};
            val_n           = 3'd5;
         end
      end
   end

   // run bytes first, value bytes after them
   always_comb begin
      burst.bytes = {32'h0, run_bytes} | (val_bytes << {run_n, 3'b000});
      burst.count = BurstCountWidth'(run_n) + BurstCountWidth'(val_n);
   end

   // pending zeros after this sample
   assign run_count_next = (is_zero && !item.block_end) ? run_len : 16'd0;

endmodule

FILE: src/zrbe_serializer.sv
module zrbe_serializer
   import zrbe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  burst_type       burst,
   input  logic            burst_load,
   output logic            burst_free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [MaxBurst*8-1:0]      bytes_ff;
   logic [MaxBurst*8-1:0]      bytes_in;
   logic [BurstCountWidth-1:0] left_ff;
   logic [BurstCountWidth-1:0] left_in;
   logic                       xfer;

   assign xfer       = rsp_valid && rsp_ready;
   assign rsp_valid  = (left_ff != '0);
   assign burst_free = (left_ff == '0) || (left_ff == BurstCountWidth'(1) && rsp_ready);

   assign rsp_payload.code_byte = bytes_ff[7:0];
   assign rsp_payload.item_done = (left_ff == BurstCountWidth'(1));

   // load a new burst or shift out one byte per transfer
   always_comb begin
      bytes_in = bytes_ff;
      left_in  = left_ff;
      if (burst_load) begin
         bytes_in = burst.bytes;
         left_in  = burst.count;
      end else if (xfer) begin
         bytes_in = bytes_ff >> 8;
         left_in  = left_ff - BurstCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

`ifndef NO_ASSERTIONS
   // a burst never overwrites bytes still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      burst_load |-> (left_ff == '0) || (left_ff == BurstCountWidth'(1) && rsp_ready))
      else $error("burst loaded over pending bytes");

   // every loaded burst holds one to eight bytes
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      burst_load |-> burst.count != '0 && burst.count <= BurstCountWidth'(MaxBurst))
      else $error("burst byte count out of range");

   // a burst stays valid until its last byte is taken
   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.item_done |=> rsp_valid)
      else $error("burst ended before last byte");
`endif

endmodule

FILE: src/zero_run_byte_encoder.sv
// Zero-run byte encoder. Each transfer on req_ carries one signed 32-bit sample;
// each transfer on rsp_ carries one byte of the code, with item_done marking the
// last byte caused by a sample. Zero samples are counted and written as a run
// code when a non-zero sample or a block end arrives, or a maximal run code when
// a zero finds the counter full. A sample is held in an input register, encoded
// in the next cycle and loaded into a byte buffer that drains one byte per cycle
// while rsp_ready is high, so the output port sets the rate. A sample causes 1 to
// 8 bytes; a zero without block end causes none unless the counter is full. The
// next sample is taken while the last byte of the previous one goes out. With
// the byte buffer free, a sample passes the input register and the byte buffer
// before its first byte is offered. Reset clears the pending run count.
module zero_run_byte_encoder
   import zrbe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_payload_ff;
   logic [15:0]     run_count_ff;
   logic [15:0]     run_count_in;
   logic [15:0]     run_count_next;
   burst_type       burst;
   logic            burst_free;
   logic            burst_load;
   logic            advance;

   // sample leaves the input register when its bytes fit or it has none
   assign advance    = in_valid_ff && (burst.count == '0 || burst_free);
   assign burst_load = advance && (burst.count != '0);
   assign req_ready  = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign run_count_in = advance ? run_count_next : run_count_ff;

   // input register and run counter
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         run_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         run_count_ff <= run_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_payload_ff <= req_payload;
      end
   end

   zrbe_encoder u_encoder (
      .item           (in_payload_ff),
      .run_count      (run_count_ff),
      .burst          (burst),
      .run_count_next (run_count_next)
   );

   zrbe_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .burst       (burst),
      .burst_load  (burst_load),
      .burst_free  (burst_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
